### rtl/msrs_pkg.sv
// Shared constants and codes for the magnetometer set/reset sequencer.
`default_nettype none

package msrs_pkg;

   // number of axes carried in a data read (1 to 3)
   localparam int AXES     = 3;
   localparam int MAX_AXES = 3;

   // payload widths
   localparam int MODE_W  = 2;
   localparam int DATA_W  = 48;
   localparam int CMD_W   = 3;
   localparam int BYTE_W  = 8;
   localparam int AXIS_W  = 16;
   localparam int DELAY_W = 8;
   localparam int POLL_W  = 4;

   // configuration port
   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_IDX_W  = 3;

   typedef logic [MODE_W-1:0] mode_type;
   typedef logic [CMD_W-1:0]  cmd_type;
   typedef logic [AXIS_W-1:0] axis_type;

   // input item kinds
   localparam mode_type MODE_START = 2'd0;
   localparam mode_type MODE_TICK  = 2'd1;
   localparam mode_type MODE_BUS   = 2'd2;

   // result commands
   localparam cmd_type CMD_WRITE  = 3'd0;
   localparam cmd_type CMD_STATUS = 3'd1;
   localparam cmd_type CMD_DATA   = 3'd2;
   localparam cmd_type CMD_READY  = 3'd3;
   localparam cmd_type CMD_FAILED = 3'd4;

   // control bytes
   localparam logic [BYTE_W-1:0] CTL_REFILL  = 8'h80;
   localparam logic [BYTE_W-1:0] CTL_SET     = 8'h20;
   localparam logic [BYTE_W-1:0] CTL_RESET   = 8'h40;
   localparam logic [BYTE_W-1:0] CTL_MEASURE = 8'h01;

   // rail readings
   localparam axis_type RAIL_LOW  = 16'h0000;
   localparam axis_type RAIL_HIGH = 16'hffff;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] REG_REFILL    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_SET_RESET = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_MEASURE   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_POLL      = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_MAX_POLLS = 3'd4;

endpackage

`default_nettype wire

### rtl/msrs_if.sv
// Valid/ready channel interfaces for sequencer events and bus commands.
`default_nettype none

interface msrs_req_if;
   logic                           valid;
   logic                           ready;
   logic [msrs_pkg::MODE_W-1:0]    mode;
   logic                           bus_ok;
   logic [msrs_pkg::DATA_W-1:0]    read_data;

   modport source (output valid, mode, bus_ok, read_data, input ready);
   modport sink   (input valid, mode, bus_ok, read_data, output ready);
endinterface

interface msrs_rsp_if;
   logic                           valid;
   logic                           ready;
   logic [msrs_pkg::CMD_W-1:0]     cmd;
   logic [msrs_pkg::BYTE_W-1:0]    cmd_value;
   logic signed [msrs_pkg::AXIS_W-1:0] field_x;
   logic signed [msrs_pkg::AXIS_W-1:0] field_y;
   logic signed [msrs_pkg::AXIS_W-1:0] field_z;
   logic [msrs_pkg::AXIS_W-1:0]    offset_x;
   logic [msrs_pkg::AXIS_W-1:0]    offset_y;
   logic [msrs_pkg::AXIS_W-1:0]    offset_z;

   modport source (output valid, cmd, cmd_value, field_x, field_y, field_z,
                   offset_x, offset_y, offset_z, input ready);
   modport sink   (input valid, cmd, cmd_value, field_x, field_y, field_z,
                   offset_x, offset_y, offset_z, output ready);
endinterface

`default_nettype wire

### rtl/magnetometer_set_reset_sequencer.sv
// Magnetometer set/reset sequencer: event register, phase logic, result register.
// Path: an item is taken into the input register, and its result (if any)
//    is then loaded into the result register, which drives rsp valid.
// Throughput: one item per cycle; the input register drains whenever the item
//    makes no result or the result register is empty or being taken.
// Reset: synchronous, active high; phase idle, counters zero, registers to defaults.
`default_nettype none

module magnetometer_set_reset_sequencer (
   input  wire logic                              clock,
   input  wire logic                              reset,
   msrs_req_if.sink                               req_ch,
   msrs_rsp_if.source                             rsp_ch,
   input  wire logic                              psel,
   input  wire logic                              penable,
   input  wire logic                              pwrite,
   input  wire logic [msrs_pkg::CSR_ADDR_W-1:0]   paddr,
   input  wire logic [msrs_pkg::CSR_DATA_W-1:0]   pwdata,
   output logic      [msrs_pkg::CSR_DATA_W-1:0]   prdata,
   output logic                                   pready
);

   // phase codes
   localparam logic [3:0] PH_IDLE       = 4'd0;
   localparam logic [3:0] PH_BUS_REFILL = 4'd1;
   localparam logic [3:0] PH_DLY_REFILL = 4'd2;
   localparam logic [3:0] PH_BUS_DIR    = 4'd3;
   localparam logic [3:0] PH_DLY_DIR    = 4'd4;
   localparam logic [3:0] PH_BUS_TM     = 4'd5;
   localparam logic [3:0] PH_DLY_MEAS   = 4'd6;
   localparam logic [3:0] PH_BUS_STATUS = 4'd7;
   localparam logic [3:0] PH_DLY_POLL   = 4'd8;
   localparam logic [3:0] PH_BUS_DATA   = 4'd9;

   localparam int AW = msrs_pkg::AXIS_W;
   localparam int NA = msrs_pkg::MAX_AXES;

   // configuration registers
   logic [msrs_pkg::DELAY_W-1:0] refill_ms_ff, set_reset_ms_ff, measure_ms_ff, poll_ms_ff;
   logic [msrs_pkg::POLL_W-1:0]  max_polls_ff;
   logic                         csr_wr;
   logic [msrs_pkg::CSR_IDX_W-1:0] csr_idx;

   // input register
   logic                               in_valid_ff;
   logic [msrs_pkg::MODE_W-1:0]        in_mode_ff;
   logic                               in_ok_ff;
   logic [msrs_pkg::DATA_W-1:0]        in_data_ff;

   // sequencer state
   logic [3:0]                   phase_ff, phase_in;
   logic [msrs_pkg::DELAY_W-1:0] wait_ff, wait_in;
   logic [msrs_pkg::POLL_W-1:0]  poll_ff, poll_in;
   logic                         pass_ff, pass_in;
   logic [AW-1:0]                set_rd_ff [NA];
   logic [AW-1:0]                set_rd_in [NA];
   logic                         set_wr;

   // result register
   logic                              out_valid_ff;
   logic [msrs_pkg::CMD_W-1:0]        out_cmd_ff;
   logic [msrs_pkg::BYTE_W-1:0]       out_value_ff;
   logic [AW-1:0]                     out_field_ff  [NA];
   logic [AW-1:0]                     out_offset_ff [NA];

   // combinational result
   logic                              res_valid;
   logic [msrs_pkg::CMD_W-1:0]        res_cmd;
   logic [msrs_pkg::BYTE_W-1:0]       res_value;
   logic                              res_fields;
   logic                              proc_fire;

   // per-axis arithmetic
   logic [AW-1:0]  rd     [NA];
   logic [AW:0]    diff   [NA];
   logic [AW:0]    diff_r [NA];
   logic [AW:0]    sum    [NA];
   logic [NA-1:0]  rail;

   // delay entry / delay exit helpers
   logic                         enter_dly;
   logic [3:0]                   dly_ph;
   logic [msrs_pkg::DELAY_W-1:0] dly_ticks;
   logic                         fire_done;
   logic [3:0]                   done_ph;
   logic                         in_dly_phase, in_bus_phase;

   //---------------------------------------------------------------------------
   // configuration port
   assign pready  = 1'b1;
   assign csr_idx = paddr[msrs_pkg::CSR_ADDR_W-1:2];
   assign csr_wr  = psel && penable && pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         refill_ms_ff    <= 8'd50;
         set_reset_ms_ff <= 8'd1;
         measure_ms_ff   <= 8'd10;
         poll_ms_ff      <= 8'd2;
         max_polls_ff    <= 4'd5;
      end else if (csr_wr) begin
         unique case (csr_idx)
            msrs_pkg::REG_REFILL:    refill_ms_ff    <= pwdata[msrs_pkg::DELAY_W-1:0];
            msrs_pkg::REG_SET_RESET: set_reset_ms_ff <= pwdata[msrs_pkg::DELAY_W-1:0];
            msrs_pkg::REG_MEASURE:   measure_ms_ff   <= pwdata[msrs_pkg::DELAY_W-1:0];
            msrs_pkg::REG_POLL:      poll_ms_ff      <= pwdata[msrs_pkg::DELAY_W-1:0];
            msrs_pkg::REG_MAX_POLLS: max_polls_ff    <= pwdata[msrs_pkg::POLL_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_idx)
         msrs_pkg::REG_REFILL:    prdata = {24'd0, refill_ms_ff};
         msrs_pkg::REG_SET_RESET: prdata = {24'd0, set_reset_ms_ff};
         msrs_pkg::REG_MEASURE:   prdata = {24'd0, measure_ms_ff};
         msrs_pkg::REG_POLL:      prdata = {24'd0, poll_ms_ff};
         msrs_pkg::REG_MAX_POLLS: prdata = {28'd0, max_polls_ff};
         default:                 prdata = '0;
      endcase
   end

   //---------------------------------------------------------------------------
   // input register: drains when its item is processed
   assign req_ch.ready = !in_valid_ff || proc_fire;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ch.ready) begin
         in_valid_ff <= req_ch.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ch.ready && req_ch.valid) begin
         in_mode_ff <= req_ch.mode;
         in_ok_ff   <= req_ch.bus_ok;
         in_data_ff <= req_ch.read_data;
      end
   end

   //---------------------------------------------------------------------------
   // per-axis readings, rail check, field and offset
   always_comb begin
      for (int a = 0; a < NA; a++) begin
         if (a < msrs_pkg::AXES) begin
            rd[a] = in_data_ff[AW*a +: AW];
         end else begin
            rd[a] = '0;
         end
         diff[a]   = {1'b0, set_rd_ff[a]} - {1'b0, rd[a]};
         // add one to negative values so the halving truncates toward zero
         diff_r[a] = diff[a] + {{AW{1'b0}}, diff[a][AW]};
         sum[a]    = {1'b0, set_rd_ff[a]} + {1'b0, rd[a]};
         rail[a]   = (a < msrs_pkg::AXES) &&
                     (set_rd_ff[a] == msrs_pkg::RAIL_LOW  ||
                      set_rd_ff[a] == msrs_pkg::RAIL_HIGH ||
                      rd[a] == msrs_pkg::RAIL_LOW || rd[a] == msrs_pkg::RAIL_HIGH);
      end
   end

   //---------------------------------------------------------------------------
   // phase logic
   assign in_dly_phase = (phase_ff == PH_DLY_REFILL) || (phase_ff == PH_DLY_DIR) ||
                         (phase_ff == PH_DLY_MEAS)   || (phase_ff == PH_DLY_POLL);
   assign in_bus_phase = (phase_ff == PH_BUS_REFILL) || (phase_ff == PH_BUS_DIR) ||
                         (phase_ff == PH_BUS_TM)     || (phase_ff == PH_BUS_STATUS) ||
                         (phase_ff == PH_BUS_DATA);

   always_comb begin
      phase_in   = phase_ff;
      wait_in    = wait_ff;
      poll_in    = poll_ff;
      pass_in    = pass_ff;
      set_wr     = 1'b0;
      for (int a = 0; a < NA; a++) set_rd_in[a] = rd[a];
      res_valid  = 1'b0;
      res_cmd    = msrs_pkg::CMD_WRITE;
      res_value  = '0;
      res_fields = 1'b0;
      enter_dly  = 1'b0;
      dly_ph     = PH_DLY_REFILL;
      dly_ticks  = '0;
      fire_done  = 1'b0;
      done_ph    = phase_ff;

      unique case (in_mode_ff)
         msrs_pkg::MODE_START: begin
            if (phase_ff == PH_IDLE) begin
               pass_in   = 1'b0;
               phase_in  = PH_BUS_REFILL;
               res_valid = 1'b1;
               res_value = msrs_pkg::CTL_REFILL;
            end
         end
         msrs_pkg::MODE_TICK: begin
            if (in_dly_phase) begin
               if (wait_ff > 8'd1) begin
                  wait_in = wait_ff - 8'd1;
               end else begin
                  wait_in   = '0;
                  fire_done = 1'b1;
               end
            end
         end
         msrs_pkg::MODE_BUS: begin
            if (in_bus_phase) begin
               if (!in_ok_ff) begin
                  phase_in  = PH_IDLE;
                  res_valid = 1'b1;
                  res_cmd   = msrs_pkg::CMD_FAILED;
               end else begin
                  unique case (phase_ff)
                     PH_BUS_REFILL: begin
                        enter_dly = 1'b1;
                        dly_ph    = PH_DLY_REFILL;
                        dly_ticks = refill_ms_ff;
                     end
                     PH_BUS_DIR: begin
                        enter_dly = 1'b1;
                        dly_ph    = PH_DLY_DIR;
                        dly_ticks = set_reset_ms_ff;
                     end
                     PH_BUS_TM: begin
                        poll_in   = '0;
                        enter_dly = 1'b1;
                        dly_ph    = PH_DLY_MEAS;
                        dly_ticks = measure_ms_ff;
                     end
                     PH_BUS_STATUS: begin
                        if (in_data_ff[0]) begin
                           phase_in  = PH_BUS_DATA;
                           res_valid = 1'b1;
                           res_cmd   = msrs_pkg::CMD_DATA;
                        end else if (poll_ff >= max_polls_ff) begin
                           phase_in  = PH_IDLE;
                           res_valid = 1'b1;
                           res_cmd   = msrs_pkg::CMD_FAILED;
                        end else begin
                           poll_in   = poll_ff + 4'd1;
                           enter_dly = 1'b1;
                           dly_ph    = PH_DLY_POLL;
                           dly_ticks = poll_ms_ff;
                        end
                     end
                     default: begin
                        // data read: end of a pass
                        res_valid = 1'b1;
                        if (!pass_ff) begin
                           set_wr    = 1'b1;
                           pass_in   = 1'b1;
                           phase_in  = PH_BUS_REFILL;
                           res_value = msrs_pkg::CTL_REFILL;
                        end else if (|rail) begin
                           phase_in = PH_IDLE;
                           res_cmd  = msrs_pkg::CMD_FAILED;
                        end else begin
                           phase_in   = PH_IDLE;
                           res_cmd    = msrs_pkg::CMD_READY;
                           res_fields = 1'b1;
                        end
                     end
                  endcase
               end
            end
         end
         default: ;
      endcase

      // a zero delay falls straight through to the next command
      if (enter_dly) begin
         if (dly_ticks == '0) begin
            fire_done = 1'b1;
            done_ph   = dly_ph;
         end else begin
            phase_in = dly_ph;
            wait_in  = dly_ticks;
         end
      end

      // delay expired: issue the following command
      if (fire_done) begin
         res_valid = 1'b1;
         unique case (done_ph)
            PH_DLY_REFILL: begin
               phase_in  = PH_BUS_DIR;
               res_value = pass_ff ? msrs_pkg::CTL_RESET : msrs_pkg::CTL_SET;
            end
            PH_DLY_DIR: begin
               phase_in  = PH_BUS_TM;
               res_value = msrs_pkg::CTL_MEASURE;
            end
            default: begin
               phase_in = PH_BUS_STATUS;
               res_cmd  = msrs_pkg::CMD_STATUS;
            end
         endcase
      end
   end

   // process the held item unless its result would collide with a stalled one
   assign proc_fire = in_valid_ff && (!res_valid || !out_valid_ff || rsp_ch.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         wait_ff  <= '0;
         poll_ff  <= '0;
         pass_ff  <= 1'b0;
      end else if (proc_fire) begin
         phase_ff <= phase_in;
         wait_ff  <= wait_in;
         poll_ff  <= poll_in;
         pass_ff  <= pass_in;
      end
   end

   // SET-pass readings
   always_ff @(posedge clock) begin
      if (proc_fire && set_wr) begin
         for (int a = 0; a < NA; a++) set_rd_ff[a] <= set_rd_in[a];
      end
   end

   //---------------------------------------------------------------------------
   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (proc_fire && res_valid) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (proc_fire && res_valid) begin
         out_cmd_ff   <= res_cmd;
         out_value_ff <= res_value;
         for (int a = 0; a < NA; a++) begin
            if (res_fields && a < msrs_pkg::AXES) begin
               out_field_ff[a]  <= diff_r[a][AW:1];
               out_offset_ff[a] <= sum[a][AW:1];
            end else begin
               out_field_ff[a]  <= '0;
               out_offset_ff[a] <= '0;
            end
         end
      end
   end

   assign rsp_ch.valid     = out_valid_ff;
   assign rsp_ch.cmd       = out_cmd_ff;
   assign rsp_ch.cmd_value = out_value_ff;
   assign rsp_ch.field_x   = out_field_ff[0];
   assign rsp_ch.field_y   = out_field_ff[1];
   assign rsp_ch.field_z   = out_field_ff[2];
   assign rsp_ch.offset_x  = out_offset_ff[0];
   assign rsp_ch.offset_y  = out_offset_ff[1];
   assign rsp_ch.offset_z  = out_offset_ff[2];

`ifndef ASSERT_OFF
   // a delay phase always has ticks left to count
   a_wait_nonzero: assert property (@(posedge clock) disable iff (reset)
      in_dly_phase |-> (wait_ff != '0))
      else $error("delay phase with zero wait count");

   // a held item that is not processed stays held
   a_in_hold: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !proc_fire) |=> in_valid_ff)
      else $error("input item dropped");

   // a ready or failed result always returns the sequencer to idle
   a_end_idle: assert property (@(posedge clock) disable iff (reset)
      (proc_fire && res_valid &&
       (res_cmd == msrs_pkg::CMD_READY || res_cmd == msrs_pkg::CMD_FAILED))
      |=> (phase_ff == PH_IDLE))
      else $error("sequence end did not return to idle");
`endif

endmodule

`default_nettype wire

### bench/magnetometer_set_reset_sequencer_test.sv
// Self-checking bench for the magnetometer set/reset sequencer: stimulus, prediction, checks.
`timescale 1ns / 100ps

module magnetometer_set_reset_sequencer_test;

   localparam msrs_pkg::mode_type MODE_UNUSED = 2'd3;
   localparam int                 IDLE_PCT    = 37;
   localparam int                 STALL_LEN   = 400;
   localparam int                 LIMIT       = 400000;

   // sequencer phases as tracked by the bench
   typedef enum logic [3:0] {
      SEQ_IDLE, SEQ_BUS_REFILL, SEQ_WAIT_REFILL, SEQ_BUS_DIR, SEQ_WAIT_DIR,
      SEQ_BUS_MEAS, SEQ_WAIT_MEAS, SEQ_BUS_STATUS, SEQ_WAIT_POLL, SEQ_BUS_DATA
   } seq_phase_type;

   // one bus command or final report
   typedef struct packed {
      msrs_pkg::cmd_type                                    cmd;
      logic [msrs_pkg::BYTE_W-1:0]                          value;
      logic [msrs_pkg::MAX_AXES-1:0][msrs_pkg::AXIS_W-1:0]  field;
      logic [msrs_pkg::MAX_AXES-1:0][msrs_pkg::AXIS_W-1:0]  offset;
   } bus_cmd_type;

   // Tracks the set/reset sequence and holds the commands still due from the block.
   class cmd_tracker;
      seq_phase_type                  state        = SEQ_IDLE;
      logic [msrs_pkg::DELAY_W-1:0]   ticks_left   = '0;
      logic [msrs_pkg::POLL_W-1:0]    polls_done   = '0;
      logic                           reset_pass   = 1'b0;
      msrs_pkg::axis_type             set_axis [msrs_pkg::MAX_AXES];
      logic [msrs_pkg::DELAY_W-1:0]   refill_ticks = 8'd50;
      logic [msrs_pkg::DELAY_W-1:0]   dir_ticks    = 8'd1;
      logic [msrs_pkg::DELAY_W-1:0]   meas_ticks   = 8'd10;
      logic [msrs_pkg::DELAY_W-1:0]   poll_ticks   = 8'd2;
      logic [msrs_pkg::POLL_W-1:0]    poll_limit   = 4'd5;
      bus_cmd_type                    due_cmds [$];
      int                             mismatches   = 0;
      string                          axis_names   = "xyz";

      function void set_reg(logic [msrs_pkg::CSR_IDX_W-1:0] idx,
                            logic [msrs_pkg::BYTE_W-1:0] value);
         case (idx)
            msrs_pkg::REG_REFILL:    refill_ticks = value;
            msrs_pkg::REG_SET_RESET: dir_ticks    = value;
            msrs_pkg::REG_MEASURE:   meas_ticks   = value;
            msrs_pkg::REG_POLL:      poll_ticks   = value;
            msrs_pkg::REG_MAX_POLLS: poll_limit   = value[msrs_pkg::POLL_W-1:0];
            default: ;
         endcase
      endfunction

      function void issue(msrs_pkg::cmd_type cmd, logic [msrs_pkg::BYTE_W-1:0] value);
         bus_cmd_type c;
         c = '0;
         c.cmd = cmd;
         c.value = value;
         due_cmds.push_back(c);
      endfunction

      function void abort();
         state = SEQ_IDLE;
         issue(msrs_pkg::CMD_FAILED, '0);
      endfunction

      // delay expired: next command goes out right away
      function void delay_over();
         case (state)
            SEQ_WAIT_REFILL: begin
               state = SEQ_BUS_DIR;
               issue(msrs_pkg::CMD_WRITE,
                     reset_pass ? msrs_pkg::CTL_RESET : msrs_pkg::CTL_SET);
            end
            SEQ_WAIT_DIR: begin
               state = SEQ_BUS_MEAS;
               issue(msrs_pkg::CMD_WRITE, msrs_pkg::CTL_MEASURE);
            end
            default: begin
               state = SEQ_BUS_STATUS;
               issue(msrs_pkg::CMD_STATUS, '0);
            end
         endcase
      endfunction

      // zero ticks skips the wait
      function void begin_delay(seq_phase_type wait_state,
                                logic [msrs_pkg::DELAY_W-1:0] ticks);
         state = wait_state;
         if (ticks == 0)
            delay_over();
         else
            ticks_left = ticks;
      endfunction

      function void take_event(msrs_pkg::mode_type mode, logic ok,
                               logic [msrs_pkg::DATA_W-1:0] data);
         msrs_pkg::axis_type rd [msrs_pkg::MAX_AXES];
         bus_cmd_type        c;
         logic               rail;
         case (mode)
            msrs_pkg::MODE_START: begin
               if (state == SEQ_IDLE) begin
                  reset_pass = 1'b0;
                  state = SEQ_BUS_REFILL;
                  issue(msrs_pkg::CMD_WRITE, msrs_pkg::CTL_REFILL);
               end
            end
            msrs_pkg::MODE_TICK: begin
               if (state inside {SEQ_WAIT_REFILL, SEQ_WAIT_DIR, SEQ_WAIT_MEAS,
                                 SEQ_WAIT_POLL}) begin
                  if (ticks_left > 1) begin
                     ticks_left--;
                  end else begin
                     ticks_left = '0;
                     delay_over();
                  end
               end
            end
            msrs_pkg::MODE_BUS: begin
               if (state inside {SEQ_BUS_REFILL, SEQ_BUS_DIR, SEQ_BUS_MEAS,
                                 SEQ_BUS_STATUS, SEQ_BUS_DATA}) begin
                  if (!ok) begin
                     abort();
                  end else begin
                     case (state)
                        SEQ_BUS_REFILL: begin_delay(SEQ_WAIT_REFILL, refill_ticks);
                        SEQ_BUS_DIR:    begin_delay(SEQ_WAIT_DIR, dir_ticks);
                        SEQ_BUS_MEAS: begin
                           polls_done = '0;
                           begin_delay(SEQ_WAIT_MEAS, meas_ticks);
                        end
                        SEQ_BUS_STATUS: begin
                           if (data[0]) begin
                              state = SEQ_BUS_DATA;
                              issue(msrs_pkg::CMD_DATA, '0);
                           end else if (polls_done >= poll_limit) begin
                              abort();
                           end else begin
                              polls_done++;
                              begin_delay(SEQ_WAIT_POLL, poll_ticks);
                           end
                        end
                        default: begin
                           // six data bytes, x in the low word
                           for (int a = 0; a < msrs_pkg::MAX_AXES; a++)
                              rd[a] = (a < msrs_pkg::AXES) ?
                                      data[msrs_pkg::AXIS_W*a +: msrs_pkg::AXIS_W] : '0;
                           if (!reset_pass) begin
                              set_axis = rd;
                              reset_pass = 1'b1;
                              state = SEQ_BUS_REFILL;
                              issue(msrs_pkg::CMD_WRITE, msrs_pkg::CTL_REFILL);
                           end else begin
                              rail = 1'b0;
                              c = '0;
                              c.cmd = msrs_pkg::CMD_READY;
                              for (int a = 0; a < msrs_pkg::AXES; a++) begin
                                 if (set_axis[a] inside {msrs_pkg::RAIL_LOW,
                                                         msrs_pkg::RAIL_HIGH} ||
                                     rd[a] inside {msrs_pkg::RAIL_LOW, msrs_pkg::RAIL_HIGH})
                                    rail = 1'b1;
                                 c.field[a]  = 16'((int'(set_axis[a]) - int'(rd[a])) / 2);
                                 c.offset[a] = 16'((int'(set_axis[a]) + int'(rd[a])) / 2);
                              end
                              if (rail) begin
                                 abort();
                              end else begin
                                 state = SEQ_IDLE;
                                 due_cmds.push_back(c);
                              end
                           end
                        end
                     endcase
                  end
               end
            end
            default: ;
         endcase
      endfunction

      function void match_cmd(bus_cmd_type got);
         bus_cmd_type want;
         if (due_cmds.size() == 0) begin
            mismatches++;
            $error("result with none due: cmd %0d", got.cmd);
            return;
         end
         want = due_cmds.pop_front();
         if (got.cmd !== want.cmd) begin
            mismatches++;
            $error("cmd: expected %0d, got %0d", want.cmd, got.cmd);
         end
         if (got.value !== want.value) begin
            mismatches++;
            $error("cmd_value: expected 0x%02h, got 0x%02h", want.value, got.value);
         end
         for (int a = 0; a < msrs_pkg::MAX_AXES; a++) begin
            if (got.field[a] !== want.field[a]) begin
               mismatches++;
               $error("field_%c: expected %0d, got %0d", axis_names[a],
                      $signed(want.field[a]), $signed(got.field[a]));
            end
            if (got.offset[a] !== want.offset[a]) begin
               mismatches++;
               $error("offset_%c: expected %0d, got %0d", axis_names[a],
                      want.offset[a], got.offset[a]);
            end
         end
      endfunction
   endclass

   logic                              clock = 1'b0;
   logic                              reset;
   logic                              psel;
   logic                              penable;
   logic                              pwrite;
   logic [msrs_pkg::CSR_ADDR_W-1:0]   paddr;
   logic [msrs_pkg::CSR_DATA_W-1:0]   pwdata;
   logic [msrs_pkg::CSR_DATA_W-1:0]   prdata;
   logic                              pready;
   bit                                steady = 1'b0;
   bit                                stall_request = 1'b0;
   int                                cycle_count = 0;

   msrs_req_if req_ch ();
   msrs_rsp_if rsp_ch ();

   cmd_tracker tracker = new();

   magnetometer_set_reset_sequencer dut (
      .clock   (clock),
      .reset   (reset),
      .req_ch  (req_ch),
      .rsp_ch  (rsp_ch),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   always #5 clock = ~clock;

   // result side: random stalls, one long hold-off on request
   initial begin
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (stall_request) begin
            stall_request = 1'b0;
            rsp_ch.ready <= 1'b0;
            repeat (STALL_LEN) @(posedge clock);
         end else begin
            rsp_ch.ready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
         end
      end
   end

   // check every accepted result
   always @(posedge clock) begin : rsp_monitor
      bus_cmd_type got;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         got.cmd       = rsp_ch.cmd;
         got.value     = rsp_ch.cmd_value;
         got.field[0]  = rsp_ch.field_x;
         got.field[1]  = rsp_ch.field_y;
         got.field[2]  = rsp_ch.field_z;
         got.offset[0] = rsp_ch.offset_x;
         got.offset[1] = rsp_ch.offset_y;
         got.offset[2] = rsp_ch.offset_z;
         tracker.match_cmd(got);
      end
   end

   // run limit
   initial begin
      while (cycle_count < LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("magnetometer_set_reset_sequencer_test NOT OK");
      $finish;
   end

   // offer one item, with random idle cycles ahead of it
   task automatic send_event(msrs_pkg::mode_type m, logic ok,
                             logic [msrs_pkg::DATA_W-1:0] d);
      while (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid     <= 1'b1;
      req_ch.mode      <= m;
      req_ch.bus_ok    <= ok;
      req_ch.read_data <= d;
      do @(posedge clock); while (!req_ch.ready);
      tracker.take_event(m, ok, d);
   endtask

   task automatic write_reg(logic [msrs_pkg::CSR_IDX_W-1:0] idx,
                            logic [msrs_pkg::BYTE_W-1:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= msrs_pkg::CSR_DATA_W'(value);
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel    <= 1'b0;
      penable <= 1'b0;
      tracker.set_reg(idx, value);
      @(posedge clock);
   endtask

   task automatic configure(logic [7:0] refill, logic [7:0] dir, logic [7:0] meas,
                            logic [7:0] poll, logic [3:0] polls);
      write_reg(msrs_pkg::REG_REFILL, refill);
      write_reg(msrs_pkg::REG_SET_RESET, dir);
      write_reg(msrs_pkg::REG_MEASURE, meas);
      write_reg(msrs_pkg::REG_POLL, poll);
      write_reg(msrs_pkg::REG_MAX_POLLS, {4'd0, polls});
   endtask

   // wait for all due results, then let items that make none drain
   task automatic settle();
      while (tracker.due_cmds.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // mostly well-formed sequences with random content; drains to idle at the end
   task automatic run_events(int count, int noise_pct);
      int                          n;
      msrs_pkg::mode_type          m;
      logic                        ok;
      logic [msrs_pkg::DATA_W-1:0] d;
      n = 0;
      while (n < count || tracker.state != SEQ_IDLE) begin
         d  = {16'($urandom), 32'($urandom)};
         ok = 1'($urandom);
         m  = msrs_pkg::mode_type'($urandom_range(0, 3));
         if (n >= count || $urandom_range(0, 99) >= noise_pct) begin
            ok = 1'b1;
            case (tracker.state)
               SEQ_IDLE: m = msrs_pkg::MODE_START;
               SEQ_WAIT_REFILL, SEQ_WAIT_DIR, SEQ_WAIT_MEAS, SEQ_WAIT_POLL:
                  m = msrs_pkg::MODE_TICK;
               default: begin
                  m  = msrs_pkg::MODE_BUS;
                  ok = $urandom_range(0, 99) >= 3;
                  if (tracker.state == SEQ_BUS_STATUS) begin
                     d[0] = $urandom_range(0, 99) < 70;
                  end else if (tracker.state == SEQ_BUS_DATA) begin
                     for (int a = 0; a < msrs_pkg::MAX_AXES; a++) begin
                        case ($urandom_range(0, 19))
                           0: d[msrs_pkg::AXIS_W*a +: msrs_pkg::AXIS_W] = msrs_pkg::RAIL_LOW;
                           1: d[msrs_pkg::AXIS_W*a +: msrs_pkg::AXIS_W] = msrs_pkg::RAIL_HIGH;
                           2: d[msrs_pkg::AXIS_W*a +: msrs_pkg::AXIS_W] = 16'h0001;
                           3: d[msrs_pkg::AXIS_W*a +: msrs_pkg::AXIS_W] = 16'hfffe;
                           4: d[msrs_pkg::AXIS_W*a +: msrs_pkg::AXIS_W] = 16'h8000;
                           5: d[msrs_pkg::AXIS_W*a +: msrs_pkg::AXIS_W] = 16'h7fff;
                           default:
                              d[msrs_pkg::AXIS_W*a +: msrs_pkg::AXIS_W] =
                                 16'($urandom_range(1, 16'hfffe));
                        endcase
                     end
                  end
               end
            endcase
         end
         send_event(m, ok, d);
         n++;
      end
      req_ch.valid <= 1'b0;
   endtask

   initial begin
      reset            <= 1'b1;
      req_ch.valid     <= 1'b0;
      req_ch.mode      <= msrs_pkg::MODE_START;
      req_ch.bus_ok    <= 1'b0;
      req_ch.read_data <= '0;
      psel             <= 1'b0;
      penable          <= 1'b0;
      pwrite           <= 1'b0;
      paddr            <= '0;
      pwdata           <= '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // directed: all delays zero, no extra polls
      configure(8'd0, 8'd0, 8'd0, 8'd0, 4'd0);
      send_event(msrs_pkg::MODE_TICK, 1'b1, '1);      // tick while idle
      send_event(msrs_pkg::MODE_BUS, 1'b1, '1);       // bus completion while idle
      send_event(MODE_UNUSED, 1'b1, '1);              // unused mode
      send_event(msrs_pkg::MODE_START, 1'b0, '0);     // refill write
      send_event(msrs_pkg::MODE_START, 1'b1, '1);     // start while busy
      send_event(msrs_pkg::MODE_TICK, 1'b0, '0);      // tick while waiting on the bus
      send_event(msrs_pkg::MODE_BUS, 1'b1, '0);       // zero delay: SET write
      send_event(msrs_pkg::MODE_BUS, 1'b1, '0);       // measure write
      send_event(msrs_pkg::MODE_BUS, 1'b1, '0);       // status read
      send_event(msrs_pkg::MODE_BUS, 1'b1, 48'hffff_ffff_fffe); // not done, poll timeout
      send_event(msrs_pkg::MODE_START, 1'b1, '0);
      send_event(msrs_pkg::MODE_BUS, 1'b0, '1);       // failed access
      send_event(msrs_pkg::MODE_START, 1'b1, '0);
      send_event(msrs_pkg::MODE_BUS, 1'b1, '0);
      send_event(msrs_pkg::MODE_BUS, 1'b1, '0);
      send_event(msrs_pkg::MODE_BUS, 1'b1, '0);
      send_event(msrs_pkg::MODE_BUS, 1'b1, 48'h0000_0000_0001); // done: data read
      send_event(msrs_pkg::MODE_BUS, 1'b1, 48'hffff_0000_7fff); // rail readings in SET pass
      send_event(msrs_pkg::MODE_BUS, 1'b1, '0);       // RESET write
      send_event(msrs_pkg::MODE_BUS, 1'b1, '0);
      send_event(msrs_pkg::MODE_BUS, 1'b1, '0);
      send_event(msrs_pkg::MODE_BUS, 1'b1, '1);
      send_event(msrs_pkg::MODE_BUS, 1'b1, 48'h0001_8000_fffe); // rail: failed
      req_ch.valid <= 1'b0;
      settle();

      // short delays, with a long result-side hold-off
      configure(8'd3, 8'd1, 8'd2, 8'd1, 4'd3);
      stall_request = 1'b1;
      run_events(300, 12);
      settle();

      // no delays, most polls, no idling on either side
      configure(8'd0, 8'd0, 8'd0, 8'd0, 4'd15);
      steady = 1'b1;
      run_events(250, 10);
      settle();
      steady = 1'b0;

      // longest refill and poll delays
      configure(8'd255, 8'd1, 8'd2, 8'd255, 4'd15);
      run_events(20, 5);
      settle();

      // mixed, frequent timeouts
      configure(8'd1, 8'd0, 8'd4, 8'd0, 4'd1);
      run_events(250, 15);
      settle();

      if (tracker.mismatches == 0 && tracker.due_cmds.size() == 0)
         $display("magnetometer_set_reset_sequencer_test OK");
      else
         $display("magnetometer_set_reset_sequencer_test NOT OK");
      $finish;
   end

endmodule

### filelist.f
rtl/msrs_pkg.sv
rtl/msrs_if.sv
rtl/magnetometer_set_reset_sequencer.sv
bench/magnetometer_set_reset_sequencer_test.sv
